// File: hw/rtl/pm_sensor_frame_parser_core_assert.svh
// ----------------------------------------------------------------------------
// Particle sensor frame parser assertion macros
// Concurrent assertion wrappers used by the parser core RTL.
// ----------------------------------------------------------------------------
`ifndef PM_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH
`define PM_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH

// assertion sampled on clk_i, off while rst_ni is low
`define PMFP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pmfp assertion failed");

// assertion sampled on clk_i at every edge, reset included
`define PMFP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pmfp assertion failed");

`endif

// File: hw/rtl/pmfp_pkg.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser package
// Status codes, frame constants, the result bundle and the ack byte lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package pmfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;
  localparam int unsigned ACK_LEN    = 7;
  localparam int unsigned FIELD_FIRST = 4;
  localparam int unsigned FIELD_LAST  = 15;
  localparam int unsigned NUM_FIELDS  = 6;

  typedef enum logic [2:0] {
    STATUS_NONE    = 3'd0,
    STATUS_DATA_OK = 3'd1,
    STATUS_ACK_OK  = 3'd2,
    STATUS_CSUM_ERR = 3'd3,
    STATUS_HDR_ERR = 3'd4
  } status_e;

  typedef struct packed {
    status_e                         status;
    logic [NUM_FIELDS-1:0][15:0]     pm;
  } result_t;

  // expected acknowledge byte at positions 0..6
  function automatic logic [7:0] ack_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h42;
      3'd1:    val = 8'h4D;
      3'd2:    val = 8'h00;
      3'd3:    val = 8'h04;
      3'd4:    val = 8'hE1;
      3'd5:    val = 8'h00;
      3'd6:    val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pmfp_frame_fsm.sv
// ----------------------------------------------------------------------------
// Particle sensor frame tracker
// Header hunt, byte position, checksum and field capture, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module pmfp_frame_fsm #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             ack_mode_i,
  output pmfp_pkg::result_t     result_o
);

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] POS_CSUM = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] POS_ACK  = CNT_W'(pmfp_pkg::ACK_LEN);
  localparam logic [CNT_W-1:0] POS_FLD0 = CNT_W'(pmfp_pkg::FIELD_FIRST);
  localparam logic [CNT_W-1:0] POS_FLDN = CNT_W'(pmfp_pkg::FIELD_LAST);

  logic             collecting_q, collecting_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      sum_q, sum_d;
  logic [7:0]       prev_q;
  logic             ack_match_q, ack_match_d;
  logic [7:0]       csum_hi_q, csum_hi_d;
  logic [7:0]       field_hi_q [pmfp_pkg::NUM_FIELDS];
  logic [7:0]       field_lo_q [pmfp_pkg::NUM_FIELDS];

  logic             restart;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] pos_off;
  logic [2:0]       fld_idx;
  logic [15:0]      sum_base;
  logic             match_base;
  logic             fld_we;
  pmfp_pkg::status_e status;

  assign restart    = collecting_q && (byte_i == pmfp_pkg::HDR_SECOND)
                      && (prev_q == pmfp_pkg::HDR_FIRST);
  assign pos        = restart ? CNT_W'(1) : cnt_q;
  assign sum_base   = restart ? 16'(pmfp_pkg::HDR_FIRST) : sum_q;
  assign match_base = restart ? 1'b1 : ack_match_q;
  assign pos_off    = pos - POS_FLD0;
  assign fld_idx    = pos_off[3:1];

  always_comb begin
    collecting_d = collecting_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    ack_match_d  = ack_match_q;
    csum_hi_d    = csum_hi_q;
    status       = pmfp_pkg::STATUS_NONE;
    fld_we       = 1'b0;
    if (!collecting_q) begin
      if (byte_i == pmfp_pkg::HDR_FIRST) begin
        collecting_d = 1'b1;
        cnt_d        = CNT_W'(1);
        sum_d        = 16'(pmfp_pkg::HDR_FIRST);
        ack_match_d  = 1'b1;
      end
    end else if ((pos == CNT_W'(1)) && (byte_i != pmfp_pkg::HDR_SECOND)) begin
      collecting_d = 1'b0;
      status       = pmfp_pkg::STATUS_HDR_ERR;
    end else if (ack_mode_i && (pos == POS_ACK)) begin
      collecting_d = 1'b0;
      status       = match_base ? pmfp_pkg::STATUS_ACK_OK : pmfp_pkg::STATUS_HDR_ERR;
    end else if (pos >= POS_LAST) begin
      collecting_d = 1'b0;
      status       = ({csum_hi_q, byte_i} == sum_base) ? pmfp_pkg::STATUS_DATA_OK
                                                       : pmfp_pkg::STATUS_CSUM_ERR;
    end else begin
      ack_match_d = match_base;
      if ((pos >= CNT_W'(2)) && (pos < POS_ACK)
          && (byte_i != pmfp_pkg::ack_byte(pos[2:0]))) begin
        ack_match_d = 1'b0;
      end
      fld_we = (pos >= POS_FLD0) && (pos <= POS_FLDN);
      if (pos < POS_CSUM) begin
        sum_d = sum_base + 16'(byte_i);
      end else begin
        sum_d     = sum_base;
        csum_hi_d = byte_i;
      end
      cnt_d = pos + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      cnt_q        <= '0;
      sum_q        <= '0;
      prev_q       <= '0;
      ack_match_q  <= 1'b1;
    end else if (step_i) begin
      collecting_q <= collecting_d;
      cnt_q        <= cnt_d;
      sum_q        <= sum_d;
      prev_q       <= byte_i;
      ack_match_q  <= ack_match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      csum_hi_q <= csum_hi_d;
      if (fld_we) begin
        if (pos[0]) begin
          field_lo_q[fld_idx] <= byte_i;
        end else begin
          field_hi_q[fld_idx] <= byte_i;
        end
      end
    end
  end

  always_comb begin
    result_o.status = status;
    for (int i = 0; i < pmfp_pkg::NUM_FIELDS; i++) begin
      result_o.pm[i] = (status == pmfp_pkg::STATUS_DATA_OK) ?
                       {field_hi_q[i], field_lo_q[i]} : 16'h0000;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pm_sensor_frame_parser_core.sv
// Output: a result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the result register frees as it is taken,
// so in_ready_o drops only while a result waits with out_ready_i low.
// Reset: asynchronous, active low; parser hunts for a header, ack_mode is 0,
// no result pending.
// ----------------------------------------------------------------------------
// Particle sensor frame parser core
// Byte-stream frame parser with checksum check and acknowledge mode.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pm_sensor_frame_parser_core_assert.svh"

module pm_sensor_frame_parser_core #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_ack_mode_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [15:0]      pm1_cf1_o,
  output logic [15:0]      pm25_cf1_o,
  output logic [15:0]      pm10_cf1_o,
  output logic [15:0]      pm1_atm_o,
  output logic [15:0]      pm25_atm_o,
  output logic [15:0]      pm10_atm_o
);

  logic              ack_mode_q;
  logic              out_valid_q;
  logic              in_fire;
  pmfp_pkg::result_t result;
  pmfp_pkg::result_t result_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  pmfp_frame_fsm #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_fire),
    .byte_i     (rx_byte_i),
    .ack_mode_i (ack_mode_q),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_mode_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ack_mode_q <= cfg_ack_mode_i;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = 3'(result_q.status);
  assign pm1_cf1_o   = result_q.pm[0];
  assign pm25_cf1_o  = result_q.pm[1];
  assign pm10_cf1_o  = result_q.pm[2];
  assign pm1_atm_o   = result_q.pm[3];
  assign pm25_atm_o  = result_q.pm[4];
  assign pm10_atm_o  = result_q.pm[5];

  // every accepted request leaves a result behind
  `PMFP_ASSERT(a_req_gives_result, in_valid_i && in_ready_o |=> out_valid_o)
  // particle values only travel with a good data frame
  `PMFP_ASSERT(a_fields_zero, out_valid_o && (status_o != 3'(pmfp_pkg::STATUS_DATA_OK))
    |-> (pm1_cf1_o == 16'h0000) && (pm25_cf1_o == 16'h0000) && (pm10_cf1_o == 16'h0000)
        && (pm1_atm_o == 16'h0000) && (pm25_atm_o == 16'h0000) && (pm10_atm_o == 16'h0000))
  // a waiting result blocks new requests
  `PMFP_ASSERT_ALWAYS(a_stall_blocks, !in_ready_o |-> out_valid_o && !out_ready_i)

endmodule

`default_nettype wire

// File: bench/pmfp_frame_checker.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser checker
// Watches the config, byte and result channels of the parser. Every accepted
// byte is run through a local model of the parser to build the expected
// result. Every accepted result is compared field by field with the oldest
// expected result. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module pmfp_frame_checker #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_ack_mode_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] pm1_cf1_i,
  input  logic [15:0] pm25_cf1_i,
  input  logic [15:0] pm10_cf1_i,
  input  logic [15:0] pm1_atm_i,
  input  logic [15:0] pm25_atm_i,
  input  logic [15:0] pm10_atm_i,
  output int          backlog_o,
  output int          errors_o
);

  localparam int unsigned CW = $clog2(FRAME_BYTES);
  localparam logic [pmfp_pkg::ACK_LEN-1:0][7:0] ACK_SEQ =
    {8'h01, 8'h00, 8'hE1, 8'h04, 8'h00, pmfp_pkg::HDR_SECOND, pmfp_pkg::HDR_FIRST};

  logic                                  ack_mode;
  logic                                  in_frame;
  logic [CW-1:0]                         frame_pos;
  logic [15:0]                           frame_sum;
  logic [7:0]                            prev_byte;
  logic [pmfp_pkg::NUM_FIELDS-1:0][15:0] pm_words;
  logic [7:0]                            sum_hi;
  logic                                  ack_intact;

  pmfp_pkg::result_t expected_results[$];
  pmfp_pkg::result_t got, want;
  string   field_name [pmfp_pkg::NUM_FIELDS] =
    '{"pm1_cf1", "pm25_cf1", "pm10_cf1", "pm1_atm", "pm25_atm", "pm10_atm"};

  function automatic pmfp_pkg::result_t parse_byte(input logic [7:0] b);
    pmfp_pkg::result_t r;
    logic [CW-1:0]     pos;
    int                fi;
    r = '0;
    r.status = pmfp_pkg::STATUS_NONE;
    if (!in_frame) begin
      if (b == pmfp_pkg::HDR_FIRST) begin
        in_frame = 1'b1;
        frame_pos = CW'(1);
        frame_sum = 16'(pmfp_pkg::HDR_FIRST);
        ack_intact = 1'b1;
      end
    end else begin
      // header seen again inside a frame: start over
      if (frame_pos != 0 && b == pmfp_pkg::HDR_SECOND && prev_byte == pmfp_pkg::HDR_FIRST) begin
        frame_pos = CW'(1);
        frame_sum = 16'(pmfp_pkg::HDR_FIRST);
        ack_intact = 1'b1;
      end
      pos = frame_pos;
      if (pos == 1 && b != pmfp_pkg::HDR_SECOND) begin
        in_frame = 1'b0;
        r.status = pmfp_pkg::STATUS_HDR_ERR;
      end else if (ack_mode && pos == pmfp_pkg::ACK_LEN) begin
        in_frame = 1'b0;
        r.status = ack_intact ? pmfp_pkg::STATUS_ACK_OK : pmfp_pkg::STATUS_HDR_ERR;
      end else if (pos >= FRAME_BYTES - 1) begin
        in_frame = 1'b0;
        if ({sum_hi, b} == frame_sum) begin
          r.status = pmfp_pkg::STATUS_DATA_OK;
          r.pm = pm_words;
        end else begin
          r.status = pmfp_pkg::STATUS_CSUM_ERR;
        end
      end else begin
        if (pos >= 2 && pos < pmfp_pkg::ACK_LEN && b != ACK_SEQ[pos]) ack_intact = 1'b0;
        if (pos >= pmfp_pkg::FIELD_FIRST && pos <= pmfp_pkg::FIELD_LAST) begin
          fi = (int'(pos) - int'(pmfp_pkg::FIELD_FIRST)) >> 1;
          if (!pos[0]) pm_words[fi] = {b, 8'h00};
          else pm_words[fi][7:0] = b;
        end
        if (pos < FRAME_BYTES - 2) frame_sum = frame_sum + 16'(b);
        else sum_hi = b;
        frame_pos = pos + 1'b1;
      end
    end
    prev_byte = b;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_mode = 1'b0;
      in_frame = 1'b0;
      frame_pos = '0;
      frame_sum = '0;
      prev_byte = '0;
      pm_words = '0;
      sum_hi = '0;
      ack_intact = 1'b1;
      expected_results.delete();
      errors_o = 0;
      backlog_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.status = pmfp_pkg::status_e'(status_i);
        got.pm = {pm10_atm_i, pm25_atm_i, pm1_atm_i, pm10_cf1_i, pm25_cf1_i, pm1_cf1_i};
        if (expected_results.size() == 0) begin
          errors_o++;
          $display("%0t: result with nothing expected, status %0d", $time, status_i);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            errors_o++;
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          end
          for (int k = 0; k < pmfp_pkg::NUM_FIELDS; k++) begin
            if (got.pm[k] !== want.pm[k]) begin
              errors_o++;
              $display("%0t: %s expected %h got %h", $time, field_name[k],
                       want.pm[k], got.pm[k]);
            end
          end
        end
      end
      // one expected result per byte request
      if (in_valid_i && in_ready_i) expected_results.push_back(parse_byte(rx_byte_i));
      if (cfg_valid_i && cfg_ready_i) ack_mode = cfg_ack_mode_i;
      backlog_o <= expected_results.size();
    end
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Particle sensor frame parser testbench
// Drives byte streams into the parser: a short directed run of header, restart
// and acknowledge cases, then phases of random well-formed data frames, ack
// sequences, corrupted frames and noise. Ack mode toggles between phases, often
// mid-frame, and each pair of phases uses its own sender and receiver idling pattern.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned FRAME_BYTES = 32;
  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 120;
  localparam int LIMIT       = 400000;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ack_mode = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  rx_byte      = 8'h00;
  logic        out_ready    = 1'b0;
  logic        cfg_ready, in_ready, out_valid;
  logic [2:0]  status;
  logic [15:0] pm1_cf1, pm25_cf1, pm10_cf1, pm1_atm, pm25_atm, pm10_atm;

  int backlog, errors;
  int cycles         = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int bytes_sent     = 0;
  int cfg_writes     = 0;
  int data_good      = 0;
  int data_bad       = 0;
  int acks_good      = 0;
  int acks_bad       = 0;

  logic [7:0] stream[$];
  logic [7:0] carry[$];

  always #10 clk = ~clk;

  pm_sensor_frame_parser_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_ack_mode_i(cfg_ack_mode),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .pm1_cf1_o     (pm1_cf1),
    .pm25_cf1_o    (pm25_cf1),
    .pm10_cf1_o    (pm10_cf1),
    .pm1_atm_o     (pm1_atm),
    .pm25_atm_o    (pm25_atm),
    .pm10_atm_o    (pm10_atm)
  );

  pmfp_frame_checker #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_ack_mode_i(cfg_ack_mode),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .rx_byte_i     (rx_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .pm1_cf1_i     (pm1_cf1),
    .pm25_cf1_i    (pm25_cf1),
    .pm10_cf1_i    (pm10_cf1),
    .pm1_atm_i     (pm1_atm),
    .pm25_atm_i    (pm25_atm),
    .pm10_atm_i    (pm10_atm),
    .backlog_o     (backlog),
    .errors_o      (errors)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, backlog);
      $display("== FAIL ==");
      $finish;
    end
  end

  // field content leans toward the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_data_frame(input logic intact);
    logic [7:0]  fr[$];
    logic [15:0] sum;
    int          k;
    fr = '{pmfp_pkg::HDR_FIRST, pmfp_pkg::HDR_SECOND, 8'h00, 8'(FRAME_BYTES - 4)};
    repeat (FRAME_BYTES - 4) fr.push_back(pick_byte());
    sum = '0;
    for (k = 0; k < FRAME_BYTES - 2; k++) sum = sum + 16'(fr[k]);
    fr[FRAME_BYTES-2] = sum[15:8];
    fr[FRAME_BYTES-1] = sum[7:0];
    if (intact) begin
      data_good++;
    end else begin
      k = $urandom_range(2, FRAME_BYTES - 1);
      fr[k] = fr[k] ^ 8'(1 << $urandom_range(0, 7));
      data_bad++;
    end
    foreach (fr[i]) stream.push_back(fr[i]);
  endtask

  task automatic add_ack(input logic intact);
    logic [7:0] fr[$];
    int         k;
    fr = '{pmfp_pkg::HDR_FIRST, pmfp_pkg::HDR_SECOND, 8'h00, 8'h04, 8'hE1, 8'h00, 8'h01,
           pick_byte()};
    if (intact) begin
      acks_good++;
    end else begin
      k = $urandom_range(2, pmfp_pkg::ACK_LEN - 1);
      fr[k] = fr[k] ^ 8'(1 << $urandom_range(0, 7));
      acks_bad++;
    end
    foreach (fr[i]) stream.push_back(fr[i]);
  endtask

  task automatic add_chunk(input logic mode);
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick >= 72) begin
      if (pick < 82) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0:       b = pmfp_pkg::HDR_FIRST;
            1:       b = pmfp_pkg::HDR_SECOND;
            default: b = 8'($urandom);
          endcase
          stream.push_back(b);
        end
      end else if (pick < 90) begin
        b = 8'($urandom);
        if (b == pmfp_pkg::HDR_SECOND) b = ~b;
        stream.push_back(pmfp_pkg::HDR_FIRST);
        stream.push_back(b);
      end else begin
        // abandoned header, then a full frame restarts it
        stream.push_back(pmfp_pkg::HDR_FIRST);
        stream.push_back(pmfp_pkg::HDR_SECOND);
        repeat ($urandom_range(0, 12)) stream.push_back(pick_byte());
        if (mode) add_ack(1'b1);
        else add_data_frame(1'b1);
      end
    end else if (!mode) begin
      if (pick < 50) add_data_frame(1'b1);
      else if (pick < 65) add_data_frame(1'b0);
      else if (pick < 70) add_ack(1'b1);
      else add_ack(1'b0);
    end else begin
      if (pick < 40) add_ack(1'b1);
      else if (pick < 60) add_ack(1'b0);
      else if (pick < 68) add_data_frame(1'b1);
      else add_data_frame(1'b0);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_stream();
    foreach (stream[i]) send_byte(stream[i]);
    in_valid <= 1'b0;
  endtask

  // register write only once every result has been taken
  task automatic write_mode(input logic mode);
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_ack_mode <= mode;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int cut;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    write_mode(1'b1);
    stream = '{8'h00, 8'hFF, pmfp_pkg::HDR_SECOND,
               pmfp_pkg::HDR_FIRST, pmfp_pkg::HDR_FIRST,
               pmfp_pkg::HDR_FIRST, pmfp_pkg::HDR_SECOND, 8'h00,
               pmfp_pkg::HDR_FIRST, pmfp_pkg::HDR_SECOND,
               8'h00, 8'h04, 8'hE1, 8'h00, 8'h01, 8'hFF,
               pmfp_pkg::HDR_FIRST, pmfp_pkg::HDR_SECOND,
               8'h00, 8'h04, 8'hE1, 8'h00, 8'h00, 8'h80};
    send_stream();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(1'(ph % 2));
      case ((ph / 2) % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 62; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 62; end
        default: begin src_idle_pct = 7;  sink_stall_pct = 7;  end
      endcase
      stream = carry;
      carry.delete();
      while (stream.size() < PHASE_BYTES) add_chunk(1'(ph % 2));
      // leave a frame partly sent so the mode flips under it
      if (ph < PHASES - 1) begin
        add_data_frame(1'b1);
        cut = $urandom_range(1, FRAME_BYTES - 1);
        repeat (cut) carry.push_front(stream.pop_back());
      end
      send_stream();
    end

    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d bytes in %0d phases, ack mode set by %0d register writes",
             bytes_sent, PHASES, cfg_writes);
    $display("generated %0d/%0d clean/corrupted data frames, %0d/%0d clean/broken acks",
             data_good, data_bad, acks_good, acks_bad);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pmfp_pkg.sv
hw/rtl/pmfp_frame_fsm.sv
hw/rtl/pm_sensor_frame_parser_core.sv
bench/pmfp_frame_checker.sv
bench/tb.sv
